// ===== rtl/rfpfc_pkg.sv =====
// Shared types and constants for the RF pulse frame capture block.
// Used by the register file, the top level and the port checker.
`default_nettype none

package rfpfc_pkg;

   // Capture bank geometry
   localparam int unsigned FRAME_DEPTH = 256;
   localparam int unsigned BANK_SLOTS  = FRAME_DEPTH + 1;
   localparam int unsigned CNT_W       = $clog2(BANK_SLOTS);
   localparam int unsigned HEAD_SLOTS  = 2;

   // Field widths
   localparam int unsigned TIME_W  = 32;
   localparam int unsigned FUNC_W  = 2;
   localparam int unsigned EST_W   = 15;
   localparam int unsigned REQ_W   = 48;
   localparam int unsigned RSP_W   = 48;

   // Configuration port
   localparam int unsigned CSR_AW  = 5;
   localparam int unsigned CSR_DW  = 32;

   // Register indexes
   localparam logic [2:0] REG_SYNC_MIN     = 3'd0;
   localparam logic [2:0] REG_SYNC_MAX     = 3'd1;
   localparam logic [2:0] REG_GLITCH       = 3'd2;
   localparam logic [2:0] REG_MIN_FRAME    = 3'd3;
   localparam logic [2:0] REG_SYNC_CAP     = 3'd4;
   localparam logic [2:0] REG_SYNC_DEFAULT = 3'd5;

   // Reset values
   localparam logic [15:0] RST_SYNC_MIN     = 16'd2500;
   localparam logic [19:0] RST_SYNC_MAX     = 20'd100000;
   localparam logic [9:0]  RST_GLITCH       = 10'd60;
   localparam logic [8:0]  RST_MIN_FRAME    = 9'd20;
   localparam logic [14:0] RST_SYNC_CAP     = 15'd10000;
   localparam logic [14:0] RST_SYNC_DEFAULT = 15'd17000;

   // Function codes
   localparam logic [FUNC_W-1:0] FUNC_EDGE    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;

   // Largest frame length a result can carry
   localparam logic [CNT_W-1:0] MAX_LENGTH = CNT_W'(BANK_SLOTS);

   typedef struct packed {
      logic [15:0] sync_min_us;
      logic [19:0] sync_max_us;
      logic [9:0]  glitch_us;
      logic [8:0]  min_frame_len;
      logic [14:0] sync_cap_us;
      logic [14:0] sync_default_us;
   } cfg_type;

endpackage

`default_nettype wire

// ===== rtl/rfpfc_csr.sv =====
// Configuration register file behind the APB-style port.
// Depends on rfpfc_pkg for register indexes, reset values and cfg_type.
`default_nettype none

module rfpfc_csr
   import rfpfc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic      [CSR_DW-1:0] csr_prdata,
   output logic                   csr_pready,
   output cfg_type                cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_AW-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_SYNC_MIN:     cfg_in.sync_min_us     = csr_pwdata[15:0];
            REG_SYNC_MAX:     cfg_in.sync_max_us     = csr_pwdata[19:0];
            REG_GLITCH:       cfg_in.glitch_us       = csr_pwdata[9:0];
            REG_MIN_FRAME:    cfg_in.min_frame_len   = csr_pwdata[8:0];
            REG_SYNC_CAP:     cfg_in.sync_cap_us     = csr_pwdata[14:0];
            REG_SYNC_DEFAULT: cfg_in.sync_default_us = csr_pwdata[14:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_SYNC_MIN:     csr_prdata = CSR_DW'(cfg_ff.sync_min_us);
         REG_SYNC_MAX:     csr_prdata = CSR_DW'(cfg_ff.sync_max_us);
         REG_GLITCH:       csr_prdata = CSR_DW'(cfg_ff.glitch_us);
         REG_MIN_FRAME:    csr_prdata = CSR_DW'(cfg_ff.min_frame_len);
         REG_SYNC_CAP:     csr_prdata = CSR_DW'(cfg_ff.sync_cap_us);
         REG_SYNC_DEFAULT: csr_prdata = CSR_DW'(cfg_ff.sync_default_us);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_min_us     <= RST_SYNC_MIN;
         cfg_ff.sync_max_us     <= RST_SYNC_MAX;
         cfg_ff.glitch_us       <= RST_GLITCH;
         cfg_ff.min_frame_len   <= RST_MIN_FRAME;
         cfg_ff.sync_cap_us     <= RST_SYNC_CAP;
         cfg_ff.sync_default_us <= RST_SYNC_DEFAULT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/rf_pulse_frame_capture.sv =====
// A transaction is held in the input register and then in the output register,
// from which its result is offered on the result channel.
// Throughput: 1 transaction per cycle while rsp_tready is high, paced by one bank
// access per item; a stalled result holds and req_tready drops once stage 1 fills.
// Reset (synchronous, active high) clears the pipeline valids, counters, flags,
// sync estimate and edge history; the capture banks start undefined.
// Top level of the RF pulse frame capture; uses rfpfc_pkg and rfpfc_csr.
`default_nettype none

module rf_pulse_frame_capture
   import rfpfc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   // Request channel
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   // [31:0] edge_time_us, [40:32] read_index, [47:41] zero
   input  wire logic [REQ_W-1:0]  req_tdata,
   // [1:0] func
   input  wire logic [FUNC_W-1:0] req_tuser,
   // Result channel
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   // [0] frame_done, [9:1] frame_length, [10] frame_pending,
   // [42:11] read_value, [47:43] zero
   output logic [RSP_W-1:0]       rsp_tdata,
   // Configuration port
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic      [CSR_DW-1:0] csr_prdata,
   output logic                   csr_pready
);

   cfg_type cfg;

   rfpfc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // ------------------------------------------------------------------
   // Input register
   // ------------------------------------------------------------------
   logic              s1_valid_ff, s1_valid_in;
   logic [FUNC_W-1:0] s1_func_ff;
   logic [TIME_W-1:0] s1_time_ff;
   logic [CNT_W-1:0]  s1_index_ff;
   logic              advance;
   logic              req_take;

   // Output register
   logic              out_valid_ff, out_valid_in;
   logic              out_done_ff;
   logic [CNT_W-1:0]  out_len_ff;
   logic              out_pend_ff;
   logic [TIME_W-1:0] out_val_ff;
   logic              out_mem_ff;
   logic              out_rbank_ff;

   // Block state
   logic              sel_ff, sel_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  com_ff, com_in;
   logic              pend_ff, pend_in;
   logic [EST_W-1:0]  est_ff, est_in;
   logic [TIME_W-1:0] last_time_ff, last_time_in;
   logic [TIME_W-1:0] last_dur_ff, last_dur_in;

   // Entries 0 and 1 of each bank (previous and opening durations) live in
   // flops, so a restart writes them in the same cycle as the memory append.
   logic [TIME_W-1:0] head_p_ff [HEAD_SLOTS];
   logic [TIME_W-1:0] head_d_ff [HEAD_SLOTS];

   // Capture banks
   logic [TIME_W-1:0] bank_zero [BANK_SLOTS];
   logic [TIME_W-1:0] bank_one  [BANK_SLOTS];
   logic [TIME_W-1:0] rd_zero_ff;
   logic [TIME_W-1:0] rd_one_ff;

   // ------------------------------------------------------------------
   // Handshake: the input register refills whenever its item moves on
   // ------------------------------------------------------------------
   assign advance    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Edge arithmetic
   // ------------------------------------------------------------------
   logic [TIME_W-1:0]   dur;
   logic                dur_small;
   logic [EST_W+3:0]    dur_x15;
   logic                lower;
   logic [EST_W-1:0]    est_low;
   logic [TIME_W+2:0]   dur_x5;
   logic [TIME_W+2:0]   est_x4;
   logic [EST_W-1:0]    sync_new;
   logic                open_c, glitch_c, close_c, full_c;
   logic [CNT_W-1:0]    cnt_close;
   logic                commit_ok;

   assign dur       = s1_time_ff - last_time_ff;
   // 15*d only matters while it can fall below a 15-bit estimate
   assign dur_small = (dur[TIME_W-1:EST_W] == '0);
   assign dur_x15   = {dur[EST_W-1:0], 4'b0000} - (EST_W+4)'(dur[EST_W-1:0]);
   assign lower     = dur_small && ((EST_W+4)'(est_ff) > dur_x15);
   assign est_low   = lower ? dur_x15[EST_W-1:0] : est_ff;
   // d > floor(est*8/10) is the same as 5*d > 4*est for integers
   assign dur_x5    = {dur, 2'b00} + (TIME_W+3)'(dur);
   assign est_x4    = (TIME_W+3)'({est_low, 2'b00});
   assign sync_new  = (dur < TIME_W'(cfg.sync_cap_us)) ? dur[EST_W-1:0]
                                                       : cfg.sync_default_us;

   assign open_c    = (cnt_ff == '0) && (dur > TIME_W'(cfg.sync_min_us))
                      && (dur < TIME_W'(cfg.sync_max_us));
   assign glitch_c  = dur < TIME_W'(cfg.glitch_us);
   assign close_c   = (cnt_ff != '0) && (dur_x5 > est_x4);
   assign full_c    = cnt_ff >= CNT_W'(FRAME_DEPTH);
   assign cnt_close = cnt_ff + CNT_W'(1);
   assign commit_ok = !pend_ff && (cnt_close >= cfg.min_frame_len);

   // ------------------------------------------------------------------
   // Next state, bank writes and result for the item leaving stage 1
   // ------------------------------------------------------------------
   logic              mem_we;
   logic              mem_wbank;
   logic [CNT_W-1:0]  mem_waddr;
   logic              mem_re;
   logic              head_we;
   logic              head_wbank;
   logic              done;
   logic              rd_hit;
   logic              rd_mem;
   logic [TIME_W-1:0] rd_head;

   assign rd_hit  = s1_index_ff < com_ff;
   assign rd_mem  = rd_hit && (s1_index_ff >= CNT_W'(HEAD_SLOTS));
   assign rd_head = s1_index_ff[0] ? head_d_ff[~sel_ff] : head_p_ff[~sel_ff];

   always_comb begin
      sel_in       = sel_ff;
      cnt_in       = cnt_ff;
      com_in       = com_ff;
      pend_in      = pend_ff;
      est_in       = est_ff;
      last_time_in = last_time_ff;
      last_dur_in  = last_dur_ff;
      mem_we       = 1'b0;
      mem_wbank    = sel_ff;
      mem_waddr    = cnt_ff;
      mem_re       = 1'b0;
      head_we      = 1'b0;
      head_wbank   = sel_ff;
      done         = 1'b0;

      if (advance) begin
         case (s1_func_ff)
            FUNC_EDGE: begin
               last_time_in = s1_time_ff;
               last_dur_in  = dur;
               est_in       = est_low;
               if (open_c) begin
                  // open a frame with the previous and the sync duration
                  head_we = 1'b1;
                  cnt_in  = CNT_W'(HEAD_SLOTS);
                  est_in  = sync_new;
               end else if (glitch_c) begin
                  cnt_in = '0;
               end else if (close_c) begin
                  // append the closing gap, commit or drop, then restart
                  est_in = sync_new;
                  mem_we = 1'b1;
                  if (commit_ok) begin
                     com_in  = cnt_close;
                     pend_in = 1'b1;
                     sel_in  = ~sel_ff;
                     done    = 1'b1;
                  end
                  head_we    = 1'b1;
                  head_wbank = sel_in;
                  cnt_in     = CNT_W'(HEAD_SLOTS);
               end else if (full_c) begin
                  // full bank: commit by force, drop this duration
                  com_in  = cnt_ff;
                  pend_in = 1'b1;
                  sel_in  = ~sel_ff;
                  done    = 1'b1;
                  cnt_in  = '0;
               end else if (cnt_ff != '0) begin
                  mem_we = 1'b1;
                  cnt_in = cnt_close;
               end
            end
            FUNC_READ: begin
               mem_re = rd_mem;
            end
            FUNC_RELEASE: begin
               com_in  = '0;
               pend_in = 1'b0;
            end
            default: begin
               // unused code: report status only
               sel_in = sel_ff;
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         sel_ff       <= 1'b0;
         cnt_ff       <= '0;
         com_ff       <= '0;
         pend_ff      <= 1'b0;
         est_ff       <= '0;
         last_time_ff <= '0;
         last_dur_ff  <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         sel_ff       <= sel_in;
         cnt_ff       <= cnt_in;
         com_ff       <= com_in;
         pend_ff      <= pend_in;
         est_ff       <= est_in;
         last_time_ff <= last_time_in;
         last_dur_ff  <= last_dur_in;
      end
   end

   // Payload of the input register
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_func_ff  <= req_tuser;
         s1_time_ff  <= req_tdata[TIME_W-1:0];
         s1_index_ff <= req_tdata[TIME_W+CNT_W-1:TIME_W];
      end
   end

   // Payload of the output register; hold while the result is stalled
   always_ff @(posedge clock) begin
      if (advance) begin
         out_done_ff  <= done;
         out_len_ff   <= com_in;
         out_pend_ff  <= pend_in;
         out_mem_ff   <= (s1_func_ff == FUNC_READ) && rd_mem;
         out_rbank_ff <= ~sel_ff;
         out_val_ff   <= ((s1_func_ff == FUNC_READ) && rd_hit) ? rd_head : '0;
      end
   end

   // Head entries of the capture bank
   always_ff @(posedge clock) begin
      if (head_we) begin
         head_p_ff[head_wbank] <= last_dur_ff;
         head_d_ff[head_wbank] <= dur;
      end
   end

   // Bank memories: one write or one read per item, read data registered
   always_ff @(posedge clock) begin
      if (mem_we && !mem_wbank) begin
         bank_zero[mem_waddr] <= dur;
      end
      if (mem_re) begin
         rd_zero_ff <= bank_zero[s1_index_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we && mem_wbank) begin
         bank_one[mem_waddr] <= dur;
      end
      if (mem_re) begin
         rd_one_ff <= bank_one[s1_index_ff];
      end
   end

   // ------------------------------------------------------------------
   // Result
   // ------------------------------------------------------------------
   logic [TIME_W-1:0] read_value;

   assign read_value = out_mem_ff ? (out_rbank_ff ? rd_one_ff : rd_zero_ff) : out_val_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_W'({read_value, out_pend_ff, out_len_ff, out_done_ff});

endmodule

`default_nettype wire

// ===== rtl/rfpfc_checker.sv =====
// Port-level checker for rf_pulse_frame_capture, attached by bind.
// Depends on rfpfc_pkg for field widths and limits.
`default_nettype none

module rfpfc_checker
   import rfpfc_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_tvalid,
   input wire logic              req_tready,
   input wire logic [REQ_W-1:0]  req_tdata,
   input wire logic [FUNC_W-1:0] req_tuser,
   input wire logic              rsp_tvalid,
   input wire logic              rsp_tready,
   input wire logic [RSP_W-1:0]  rsp_tdata,
   input wire logic              csr_psel,
   input wire logic              csr_penable,
   input wire logic              csr_pwrite,
   input wire logic [CSR_AW-1:0] csr_paddr,
   input wire logic [CSR_DW-1:0] csr_pwdata,
   input wire logic [CSR_DW-1:0] csr_prdata,
   input wire logic              csr_pready
);

   logic             rsp_done;
   logic [CNT_W-1:0] rsp_len;
   logic             rsp_pend;

   assign rsp_done = rsp_tdata[0];
   assign rsp_len  = rsp_tdata[CNT_W:1];
   assign rsp_pend = rsp_tdata[CNT_W+1];

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // No result right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A commit always leaves a frame pending
   a_done_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_done |-> rsp_pend)
      else $error("frame done without pending frame");

   // Pending and a nonzero, bounded length go together
   a_len_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_pend == (rsp_len != '0)) && (rsp_len <= MAX_LENGTH))
      else $error("frame length inconsistent with pending flag");

endmodule

bind rf_pulse_frame_capture rfpfc_checker u_rfpfc_checker (.*);

`default_nettype wire

// ===== test/rf_pulse_frame_capture_test.sv =====
// Self-checking testbench for rf_pulse_frame_capture: edge, read and release traffic
// checked against a built-in frame capture predictor. Depends on rfpfc_pkg and the RTL.

module rf_pulse_frame_capture_test
   import rfpfc_pkg::*;
();

   typedef struct packed {
      logic [31:0]      read_value;
      logic             frame_pending;
      logic [CNT_W-1:0] frame_length;
      logic             frame_done;
   } frame_status_type;

   class pulse_frame_tracker;
      cfg_type          cfg;
      logic [31:0]      bank [2][BANK_SLOTS];
      logic             capture_sel;
      logic [CNT_W-1:0] capture_len;
      logic [CNT_W-1:0] committed_len;
      logic             pending;
      logic [EST_W-1:0] sync_est;
      logic [31:0]      prev_stamp;
      logic [31:0]      prev_width;
      frame_status_type expected_status [$];
      int unsigned      errors;
      int unsigned      checked;

      function new();
         cfg.sync_min_us     = RST_SYNC_MIN;
         cfg.sync_max_us     = RST_SYNC_MAX;
         cfg.glitch_us       = RST_GLITCH;
         cfg.min_frame_len   = RST_MIN_FRAME;
         cfg.sync_cap_us     = RST_SYNC_CAP;
         cfg.sync_default_us = RST_SYNC_DEFAULT;
         foreach (bank[b, i]) bank[b][i] = '0;
         capture_sel   = 1'b0;
         capture_len   = '0;
         committed_len = '0;
         pending       = 1'b0;
         sync_est      = '0;
         prev_stamp    = '0;
         prev_width    = '0;
         errors        = 0;
         checked       = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] val);
         case (idx)
            REG_SYNC_MIN:     cfg.sync_min_us     = val[15:0];
            REG_SYNC_MAX:     cfg.sync_max_us     = val[19:0];
            REG_GLITCH:       cfg.glitch_us       = val[9:0];
            REG_MIN_FRAME:    cfg.min_frame_len   = val[8:0];
            REG_SYNC_CAP:     cfg.sync_cap_us     = val[14:0];
            REG_SYNC_DEFAULT: cfg.sync_default_us = val[14:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] reg_value(logic [2:0] idx);
         case (idx)
            REG_SYNC_MIN:     return 32'(cfg.sync_min_us);
            REG_SYNC_MAX:     return 32'(cfg.sync_max_us);
            REG_GLITCH:       return 32'(cfg.glitch_us);
            REG_MIN_FRAME:    return 32'(cfg.min_frame_len);
            REG_SYNC_CAP:     return 32'(cfg.sync_cap_us);
            REG_SYNC_DEFAULT: return 32'(cfg.sync_default_us);
            default:          return '0;
         endcase
      endfunction

      function void append(logic [31:0] width);
         if (capture_len < BANK_SLOTS) begin
            bank[capture_sel][capture_len] = width;
            capture_len++;
         end
      endfunction

      function void start_frame(logic [31:0] prior, logic [31:0] width);
         capture_len = '0;
         append(prior);
         append(width);
      endfunction

      function void load_estimate(logic [31:0] width);
         sync_est = (width < 32'(cfg.sync_cap_us)) ? width[EST_W-1:0] : cfg.sync_default_us;
      endfunction

      // Swap banks: the filled capture bank becomes the readable one
      function void commit_frame();
         committed_len = capture_len;
         pending       = 1'b1;
         capture_sel   = ~capture_sel;
      endfunction

      function int unsigned outstanding();
         return expected_status.size();
      endfunction

      function void take_request(logic [FUNC_W-1:0] func, logic [31:0] stamp,
                                 logic [CNT_W-1:0] index);
         frame_status_type  s;
         logic [31:0]       width;
         logic [31:0]       prior;
         longint unsigned   ceiling;
         s = '0;
         case (func)
            FUNC_EDGE: begin
               prior   = prev_width;
               width   = stamp - prev_stamp;
               ceiling = 64'(width) * 64'd15;
               // The estimate never exceeds fifteen times the newest duration
               if (64'(sync_est) > ceiling) sync_est = EST_W'(ceiling);
               prev_stamp = stamp;
               prev_width = width;
               if (capture_len == 0 && width > 32'(cfg.sync_min_us)
                   && width < 32'(cfg.sync_max_us)) begin
                  start_frame(prior, width);
                  load_estimate(width);
               end else if (width < 32'(cfg.glitch_us)) begin
                  capture_len = '0;
               end else if (capture_len != 0
                            && width > (32'(sync_est) * 32'd8) / 32'd10) begin
                  load_estimate(width);
                  append(width);
                  if (!pending && capture_len >= cfg.min_frame_len) begin
                     commit_frame();
                     s.frame_done = 1'b1;
                  end
                  start_frame(prior, width);
               end else if (capture_len >= FRAME_DEPTH) begin
                  commit_frame();
                  s.frame_done = 1'b1;
                  capture_len  = '0;
               end else if (capture_len != 0) begin
                  append(width);
               end
            end
            FUNC_READ: begin
               if (index < committed_len) s.read_value = bank[~capture_sel][index];
            end
            FUNC_RELEASE: begin
               committed_len = '0;
               pending       = 1'b0;
            end
            default: ;
         endcase
         s.frame_length  = committed_len;
         s.frame_pending = pending;
         expected_status.push_back(s);
      endfunction

      task report_mismatch(string what);
         $display("[%0t] mismatch: %s", $time, what);
         errors++;
      endtask

      task check_status(logic [RSP_W-1:0] data);
         frame_status_type got;
         frame_status_type want;
         got = frame_status_type'(data[42:0]);
         if (expected_status.size() == 0) begin
            report_mismatch($sformatf("result 0x%012h with nothing expected", data));
         end else begin
            want = expected_status.pop_front();
            if (got.frame_done !== want.frame_done)
               report_mismatch($sformatf("result %0d frame_done got %0b want %0b",
                                         checked, got.frame_done, want.frame_done));
            if (got.frame_length !== want.frame_length)
               report_mismatch($sformatf("result %0d frame_length got %0d want %0d",
                                         checked, got.frame_length, want.frame_length));
            if (got.frame_pending !== want.frame_pending)
               report_mismatch($sformatf("result %0d frame_pending got %0b want %0b",
                                         checked, got.frame_pending, want.frame_pending));
            if (got.read_value !== want.read_value)
               report_mismatch($sformatf("result %0d read_value got 0x%08h want 0x%08h",
                                         checked, got.read_value, want.read_value));
         end
         if (data[RSP_W-1:43] !== '0)
            report_mismatch($sformatf("result %0d padding bits not zero", checked));
         checked++;
      endtask
   endclass

   localparam int unsigned QUIET_LIMIT = 1000;
   // Function code that the block does not use
   localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   // [31:0] edge_time_us, [40:32] read_index, [47:41] zero
   logic [REQ_W-1:0]  req_tdata;
   // [1:0] func
   logic [FUNC_W-1:0] req_tuser;
   logic              rsp_tvalid;
   logic              rsp_tready;
   // [0] frame_done, [9:1] frame_length, [10] frame_pending, [42:11] read_value, [47:43] zero
   logic [RSP_W-1:0]  rsp_tdata;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   pulse_frame_tracker tracker;

   logic [31:0] now_us;      // timestamp of the last edge sent
   bit          idle_on;     // allow random gaps on both channels
   int unsigned sent;        // request transactions accepted so far
   int unsigned quiet;       // cycles since anything moved
   int unsigned stall_left;

   rf_pulse_frame_capture dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Sample both channels at the rising edge; inputs only move on the falling edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) tracker.check_status(rsp_tdata);
         if (req_tvalid && req_tready) begin
            tracker.take_request(req_tuser, req_tdata[31:0], req_tdata[40:32]);
            sent++;
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
            quiet = 0;
         else
            quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Result side back-pressure: while idling is allowed, drop ready for random bursts
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_tready = 1'b0;
         stall_left--;
      end else if (!reset && idle_on && $urandom_range(0, 5) == 0) begin
         rsp_tready = 1'b0;
         stall_left = $urandom_range(0, 2);
      end else begin
         rsp_tready = 1'b1;
      end
   end

   // Present one transaction and hold it until accepted; valid stays high on return.
   task automatic send_item(input logic [FUNC_W-1:0] func, input logic [31:0] stamp,
                            input logic [CNT_W-1:0] index);
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = func;
      req_tdata  = {7'b0, index, stamp};
      do @(posedge clock); while (!req_tready);
   endtask

   // Advance the timestamp by one duration and send the edge
   task automatic pulse(input logic [31:0] dur);
      now_us = now_us + dur;
      send_item(FUNC_EDGE, now_us, CNT_W'($urandom_range(0, 256)));
   endtask

   task automatic read_entry(input int unsigned index);
      send_item(FUNC_READ, $urandom, CNT_W'(index));
   endtask

   task automatic release_frame();
      send_item(FUNC_RELEASE, $urandom, CNT_W'($urandom_range(0, 256)));
   endtask

   // Drop valid and wait for every expected result to come back
   task automatic settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [2:0] idx, input logic [31:0] val);
      logic [31:0] want;
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = wr;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = wr ? val : '0;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      if (wr) begin
         tracker.write_reg(idx, val);
      end else begin
         want = tracker.reg_value(idx);
         if (csr_prdata !== want)
            tracker.report_mismatch($sformatf("register %0d read 0x%08h want 0x%08h",
                                              idx, csr_prdata, want));
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // Write all six registers while idle, then read them back
   task automatic load_config(input cfg_type c);
      settle();
      csr_access(1'b1, REG_SYNC_MIN,     32'(c.sync_min_us));
      csr_access(1'b1, REG_SYNC_MAX,     32'(c.sync_max_us));
      csr_access(1'b1, REG_GLITCH,       32'(c.glitch_us));
      csr_access(1'b1, REG_MIN_FRAME,    32'(c.min_frame_len));
      csr_access(1'b1, REG_SYNC_CAP,     32'(c.sync_cap_us));
      csr_access(1'b1, REG_SYNC_DEFAULT, 32'(c.sync_default_us));
      csr_access(1'b0, REG_SYNC_MIN,     '0);
      csr_access(1'b0, REG_SYNC_MAX,     '0);
      csr_access(1'b0, REG_GLITCH,       '0);
      csr_access(1'b0, REG_MIN_FRAME,    '0);
      csr_access(1'b0, REG_SYNC_CAP,     '0);
      csr_access(1'b0, REG_SYNC_DEFAULT, '0);
   endtask

   // Mostly well-formed frames (sync, pulses, sync) with reads and releases,
   // mixed with broken frames, glitches, timestamp jumps and unused functions.
   task automatic run_traffic(input int unsigned n_items,
                              input int unsigned sync_lo, input int unsigned sync_hi,
                              input int unsigned pulse_lo, input int unsigned pulse_hi);
      int unsigned goal;
      int unsigned pulses;
      int unsigned pick;
      int unsigned glitch;
      goal = sent + n_items;
      while (sent < goal) begin
         pick   = $urandom_range(0, 9);
         glitch = tracker.cfg.glitch_us;
         if (pick <= 5) begin
            pulse($urandom_range(sync_lo, sync_hi));
            pulses = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40)
                                                 : $urandom_range(1, 12);
            repeat (pulses) pulse($urandom_range(pulse_lo, pulse_hi));
            // Now and then break the frame with a glitch instead of a closing gap
            if ($urandom_range(0, 5) == 0)
               pulse(glitch == 0 ? 0 : $urandom_range(0, glitch - 1));
            else
               pulse($urandom_range(sync_lo, sync_hi));
            repeat ($urandom_range(0, 3)) read_entry($urandom_range(0, pulses + 4));
            if ($urandom_range(0, 1) == 1) release_frame();
         end else if (pick == 6) begin
            read_entry($urandom_range(0, 256));
         end else if (pick == 7) begin
            release_frame();
         end else if (pick == 8) begin
            case ($urandom_range(0, 2))
               0: pulse(glitch == 0 ? 0 : $urandom_range(0, glitch - 1));
               1: begin
                  now_us = $urandom;
                  send_item(FUNC_EDGE, now_us, CNT_W'($urandom_range(0, 256)));
               end
               default: send_item(FUNC_SPARE, $urandom, CNT_W'($urandom_range(0, 256)));
            endcase
         end else begin
            pulse($urandom_range(0, 300000));
         end
      end
   endtask

   initial begin
      cfg_type c;
      tracker     = new();
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = FUNC_EDGE;
      rsp_tready  = 1'b1;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      now_us      = '0;
      idle_on     = 1'b1;
      sent        = 0;
      quiet       = 0;
      stall_left  = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part under reset configuration.
      // Read and release with nothing committed, and an unused function code.
      read_entry(0);
      release_frame();
      send_item(FUNC_SPARE, 32'hFFFF_FFFF, 9'h1FF);
      // Huge gap beyond the sync window, then a gap that wraps the timestamp
      now_us = 32'hFFFF_F000;
      send_item(FUNC_EDGE, now_us, '0);
      pulse(32'h0000_1B00);
      // Glitch aborts the open frame; reopen after it
      pulse(10);
      pulse(6000);
      // Shortest frame that the reset minimum length lets through
      repeat (17) pulse(500);
      pulse(6000);
      // Last entry, one past the end, and the top index
      read_entry(19);
      read_entry(20);
      read_entry(256);
      release_frame();

      // Typical timing, short frames accepted
      c = '{sync_min_us: 16'd2500, sync_max_us: 20'd100000, glitch_us: 10'd60,
            min_frame_len: 9'd3, sync_cap_us: 15'd10000, sync_default_us: 15'd17000};
      load_config(c);
      run_traffic(30, 3000, 9000, 200, 1200);

      // Lower extremes: every nonzero gap opens or closes a frame, no glitch filter
      c = '{sync_min_us: 16'd0, sync_max_us: 20'hFFFFF, glitch_us: 10'd0,
            min_frame_len: 9'd3, sync_cap_us: 15'd0, sync_default_us: 15'd0};
      load_config(c);
      idle_on = 1'b0;
      run_traffic(20, 0, 4000, 0, 3);

      // Upper extremes: only the longest frames survive
      c = '{sync_min_us: 16'hFFFF, sync_max_us: 20'hFFFFF, glitch_us: 10'h3FF,
            min_frame_len: 9'd257, sync_cap_us: 15'h7FFF, sync_default_us: 15'h7FFF};
      load_config(c);
      idle_on = 1'b1;
      // Frame that overruns the bank and is committed by force
      release_frame();
      pulse(100000);
      repeat (255) pulse($urandom_range(1100, 2000));
      read_entry(255);
      read_entry(256);
      read_entry(0);
      run_traffic(15, 70000, 300000, 1100, 2000);

      // Final stretch without any idling
      c = '{sync_min_us: 16'd1000, sync_max_us: 20'd50000, glitch_us: 10'd100,
            min_frame_len: 9'd8, sync_cap_us: 15'd5000, sync_default_us: 15'd12000};
      load_config(c);
      idle_on = 1'b0;
      run_traffic(45, 2500, 20000, 150, 600);

      // Drain, then give a stray result time to show up
      settle();
      repeat (4) @(posedge clock);
      if (tracker.outstanding() != 0)
         tracker.report_mismatch($sformatf("%0d results never arrived",
                                           tracker.outstanding()));
      if (tracker.errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
